>>> rtl/slpm_pkg.sv
`timescale 1ns / 1ps

package slpm_pkg;

	localparam int TOTAL_W = 32;
	localparam int SEC_W   = 23;
	localparam int AMT_W   = 17;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;

	// floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
	localparam int RECIP_W     = 29;
	localparam int RECIP_SHIFT = 38;
	localparam int PROD_W      = TOTAL_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = 1;

	localparam logic [CFG_W-1:0] MIN_DARK_RST  = 16'd2000;
	localparam logic [CFG_W-1:0] FLASH_MIN_RST = 16'd400;
	localparam logic [CFG_W-1:0] FLASH_MAX_RST = 16'd800;
	localparam logic [CFG_W-1:0] END_QUIET_RST = 16'd2000;

	localparam logic [1:0] COUNT_MAX = 2'd2;

	typedef enum logic [IDX_W-1:0] {
		CFG_MIN_DARK  = 2'd0,
		CFG_FLASH_MIN = 2'd1,
		CFG_FLASH_MAX = 2'd2,
		CFG_END_QUIET = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_ON    = 2'd1,
		MODE_FLASH = 2'd2
	} mode_t;

	// one filtered sample, as queued between front and back
	typedef struct packed {
		logic        level;
		logic        rise;
		logic        fall;
		logic [31:0] now_ms;
	} smp_t;

	// control decisions for one sample, handed to the accumulator
	typedef struct packed {
		logic               level;
		mode_t              mode;
		logic               flashing;
		logic               measuring;
		logic               active;
		logic               done;
		logic               clear;
		logic               flash_add;
		logic               steady_add;
		logic [AMT_W-1:0]   flash_amt;
		logic [TOTAL_W-1:0] steady_amt;
	} ev_t;

endpackage

>>> rtl/slpm_front.sv
`timescale 1ns / 1ps

module slpm_front import slpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        lamp_raw,
	input  logic [31:0] now_ms,
	input  logic        q_full,
	output logic        push,
	output smp_t        push_item
);

	logic [2:0] window_q;
	logic       prev_q;
	logic [2:0] window_nxt;
	logic       level;

	assign in_ready   = !q_full;
	assign push       = in_valid && in_ready;
	assign window_nxt = {window_q[1:0], lamp_raw};
	// 2-of-3 majority
	assign level = (window_nxt[0] & window_nxt[1]) | (window_nxt[0] & window_nxt[2]) |
		(window_nxt[1] & window_nxt[2]);

	always_comb begin
		push_item.level  = level;
		push_item.rise   = level && !prev_q;
		push_item.fall   = !level && prev_q;
		push_item.now_ms = now_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			prev_q   <= 1'b0;
		end else if (push) begin
			window_q <= window_nxt;
			prev_q   <= level;
		end
	end

endmodule

>>> rtl/slpm_fifo.sv
`timescale 1ns / 1ps

module slpm_fifo import slpm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  smp_t push_item,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output smp_t head
);

	smp_t            mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   count_q;

	assign full     = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop && !full |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a beat");

endmodule

>>> rtl/slpm_ctrl.sv
`timescale 1ns / 1ps

module slpm_ctrl import slpm_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             q_valid,
	input  smp_t             q_item,
	input  logic             adv,
	output logic             pop,
	output logic             ev_valid,
	output ev_t              ev
);

	logic [CFG_W-1:0] min_dark_q, flash_min_q, flash_max_q, end_quiet_q;

	logic [TIME_BITS-1:0] dark_start_q, light_start_q, last_off_q, last_dark_q;
	logic                 awaiting_q, measure_q, active_q, flash_q;
	logic [1:0]           count_q;
	mode_t                mode_q;

	logic [TIME_BITS-1:0] dark_start_n, light_start_n, last_off_n, last_dark_n;
	logic                 awaiting_n, measure_n, active_n, flash_n;
	logic [1:0]           count_n;
	mode_t                mode_n;

	logic [TIME_BITS-1:0] now_t, dark, light, quiet;
	logic                 light_band, dark_band;
	ev_t                  ev_n;
	logic                 ev_valid_s1;
	ev_t                  ev_s1;

	assign pop = q_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dark_q  <= MIN_DARK_RST;
			flash_min_q <= FLASH_MIN_RST;
			flash_max_q <= FLASH_MAX_RST;
			end_quiet_q <= END_QUIET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_DARK:  min_dark_q  <= cfg_data;
				CFG_FLASH_MIN: flash_min_q <= cfg_data;
				CFG_FLASH_MAX: flash_max_q <= cfg_data;
				CFG_END_QUIET: end_quiet_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		now_t = TIME_BITS'(q_item.now_ms);
		dark  = now_t - dark_start_q;
		light = now_t - light_start_q;
		quiet = now_t - last_off_q;
		light_band = (light >= TIME_BITS'(flash_min_q)) && (light <= TIME_BITS'(flash_max_q));
		dark_band  = (last_dark_q >= TIME_BITS'(flash_min_q)) &&
			(last_dark_q <= TIME_BITS'(flash_max_q));

		dark_start_n  = dark_start_q;
		light_start_n = light_start_q;
		last_off_n    = last_off_q;
		last_dark_n   = last_dark_q;
		awaiting_n    = awaiting_q;
		measure_n     = measure_q;
		active_n      = active_q;
		flash_n       = flash_q;
		count_n       = count_q;
		mode_n        = mode_q;

		ev_n            = '0;
		// both periods are inside the flash band when this amount is used
		ev_n.flash_amt  = AMT_W'(light[CFG_W-1:0]) + AMT_W'(last_dark_q[CFG_W-1:0]);
		ev_n.steady_amt = (|(light >> TOTAL_W)) ? '1 : TOTAL_W'(light);

		if (q_item.rise) begin
			last_dark_n   = dark;
			light_start_n = now_t;
			mode_n        = MODE_ON;
			if (awaiting_q && dark >= TIME_BITS'(min_dark_q)) begin
				measure_n  = 1'b1;
				awaiting_n = 1'b0;
				ev_n.clear = 1'b1;
				if (count_q != COUNT_MAX) begin
					count_n = count_q + 1'b1;
				end
				active_n = (count_n == COUNT_MAX);
			end
		end else if (q_item.fall) begin
			last_off_n   = now_t;
			dark_start_n = now_t;
			mode_n       = MODE_OFF;
			if (light_band && dark_band) begin
				if (!flash_q) begin
					flash_n = 1'b1;
					mode_n  = MODE_FLASH;
				end
				ev_n.flash_add = 1'b1;
			end else begin
				flash_n = 1'b0;
				ev_n.steady_add = measure_q && (light > TIME_BITS'(flash_max_q));
			end
		end

		// a falling edge restarts the quiet time, so no end of measurement there
		if (measure_q && !q_item.level && !q_item.fall &&
			quiet > TIME_BITS'(end_quiet_q)) begin
			active_n   = 1'b0;
			measure_n  = 1'b0;
			awaiting_n = 1'b1;
			ev_n.done  = 1'b1;
		end

		ev_n.level     = q_item.level;
		ev_n.mode      = mode_n;
		ev_n.flashing  = flash_n;
		ev_n.measuring = measure_n;
		ev_n.active    = active_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_start_q  <= '0;
			light_start_q <= '0;
			last_off_q    <= '0;
			last_dark_q   <= '0;
			awaiting_q    <= 1'b1;
			measure_q     <= 1'b0;
			active_q      <= 1'b0;
			flash_q       <= 1'b0;
			count_q       <= '0;
			mode_q        <= MODE_OFF;
			ev_valid_s1   <= 1'b0;
		end else begin
			if (pop) begin
				dark_start_q  <= dark_start_n;
				light_start_q <= light_start_n;
				last_off_q    <= last_off_n;
				last_dark_q   <= last_dark_n;
				awaiting_q    <= awaiting_n;
				measure_q     <= measure_n;
				active_q      <= active_n;
				flash_q       <= flash_n;
				count_q       <= count_n;
				mode_q        <= mode_n;
			end
			if (adv) begin
				ev_valid_s1 <= pop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_s1 <= ev_n;
		end
	end

	assign ev_valid = ev_valid_s1;
	assign ev       = ev_s1;

	assert property (@(posedge clk) disable iff (!arst_n)
		measure_q != awaiting_q) else $error("measure and awaiting-dark both set or both clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> measure_q) else $error("countdown active outside a measurement");
	assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid_s1 && ev_s1.done |-> !ev_s1.level && !ev_s1.measuring)
		else $error("measurement ended on a lit sample");

endmodule

>>> rtl/slpm_accum.sv
`timescale 1ns / 1ps

module slpm_accum import slpm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ev_valid,
	input  ev_t                ev,
	output logic               adv,
	output logic               out_valid,
	input  logic               out_ready,
	output ev_t                out_ev,
	output logic [SEC_W-1:0]   seconds
);

	logic [TOTAL_W-1:0] flash_total_q, steady_total_q;
	logic [TOTAL_W:0]   flash_sum, steady_sum, both_sum;
	logic [TOTAL_W-1:0] total_s2;
	logic [PROD_W-1:0]  prod_s3;
	ev_t                ev_s2, ev_s3, out_q;
	logic               v_s2, v_s3, v_out_q;
	logic [SEC_W-1:0]   seconds_q;

	assign adv = !v_out_q || out_ready;

	assign flash_sum  = {1'b0, flash_total_q} + (TOTAL_W+1)'(ev.flash_amt);
	assign steady_sum = {1'b0, steady_total_q} + {1'b0, ev.steady_amt};
	// totals are not touched on the sample that ends a measurement
	assign both_sum   = {1'b0, flash_total_q} + {1'b0, steady_total_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_total_q  <= '0;
			steady_total_q <= '0;
			seconds_q      <= '0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_out_q        <= 1'b0;
		end else if (adv) begin
			v_s2    <= ev_valid;
			v_s3    <= v_s2;
			v_out_q <= v_s3;
			if (ev_valid) begin
				if (ev.clear) begin
					flash_total_q  <= '0;
					steady_total_q <= '0;
				end else if (ev.flash_add) begin
					flash_total_q <= flash_sum[TOTAL_W] ? '1 : flash_sum[TOTAL_W-1:0];
				end else if (ev.steady_add) begin
					steady_total_q <= steady_sum[TOTAL_W] ? '1 : steady_sum[TOTAL_W-1:0];
				end
			end
			if (v_s3 && ev_s3.done) begin
				seconds_q <= prod_s3[RECIP_SHIFT +: SEC_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_s2    <= ev;
			total_s2 <= both_sum[TOTAL_W] ? '1 : both_sum[TOTAL_W-1:0];
			ev_s3    <= ev_s2;
			prod_s3  <= PROD_W'(total_s2) * PROD_W'(RECIP_1000);
			out_q    <= ev_s3;
		end
	end

	assign out_valid = v_out_q;
	assign out_ev    = out_q;
	assign seconds   = seconds_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && ev_valid && ev.clear |=> flash_total_q == '0 && steady_total_q == '0)
		else $error("totals not cleared at measurement start");

endmodule

>>> rtl/signal_lamp_period_meter_core.sv
`timescale 1ns / 1ps
// Lamp period meter: one raw lamp sample with a millisecond timestamp per input beat,
// one status beat out per input beat, in order.
// Input channel in_valid/in_ready carries lamp_raw and now_ms. The front end
// runs the 2-of-3 majority filter and edge detection and drops the sample into a
// two-entry queue; in_ready is low only while that queue is full.
// The back end takes one sample per cycle while not held: a control stage (edges,
// flash/steady classification, measurement start and end), an accumulate stage
// (saturating totals and their sum), a multiply stage (divide by 1000 through a
// reciprocal) and the output register. Output channel out_valid/out_ready.
// An input beat passes the queue and the control, accumulate, multiply and output
// registers before out_valid; throughput is one beat per cycle when not stalled.
// When out_ready is low with an output beat pending, the whole back end holds;
// the queue fills up to its two entries, then in_ready drops until the output drains.
// cfg_we writes register cfg_index with cfg_data at once; write only while idle.
// Reset (arst_n low) restores the register defaults, empties the queue and
// pipeline and clears all timing state; no output beat is pending afterwards.
module signal_lamp_period_meter_core import slpm_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 lamp_raw,
	input  logic [31:0]          now_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 lamp_level,
	output logic [1:0]           lamp_mode,
	output logic                 flashing,
	output logic                 measuring,
	output logic                 countdown_active,
	output logic                 measure_done,
	output logic [SEC_W-1:0]     countdown_seconds
);

	logic push, q_full, q_nonempty, pop, adv, ev_valid;
	smp_t push_item, q_head;
	ev_t  ev, out_ev;

	slpm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.lamp_raw  (lamp_raw),
		.now_ms    (now_ms),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	slpm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	slpm_ctrl #(
		.TIME_BITS (TIME_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_nonempty),
		.q_item    (q_head),
		.adv       (adv),
		.pop       (pop),
		.ev_valid  (ev_valid),
		.ev        (ev)
	);

	slpm_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_valid),
		.ev        (ev),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_ev    (out_ev),
		.seconds   (countdown_seconds)
	);

	assign lamp_level       = out_ev.level;
	assign lamp_mode        = out_ev.mode;
	assign flashing         = out_ev.flashing;
	assign measuring        = out_ev.measuring;
	assign countdown_active = out_ev.active;
	assign measure_done     = out_ev.done;

endmodule

>>> tb/sv/lamp_meter_checker.sv
`timescale 1ns / 1ps

module lamp_meter_checker import slpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             lamp_raw,
	input  logic [31:0]      now_ms,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic             lamp_level,
	input  logic [1:0]       lamp_mode,
	input  logic             flashing,
	input  logic             measuring,
	input  logic             countdown_active,
	input  logic             measure_done,
	input  logic [SEC_W-1:0] countdown_seconds,
	output int               mismatches,
	output int               status_pending
);

	typedef struct packed {
		logic             lamp;
		mode_t            mode;
		logic             flash;
		logic             meas;
		logic             active;
		logic             done;
		logic [SEC_W-1:0] secs;
	} lamp_status_t;

	lamp_status_t status_due[$];
	lamp_status_t want;
	int err_count = 0;

	logic [CFG_W-1:0] min_dark, flash_min, flash_max, end_quiet;

	logic [2:0]       window;
	logic             filt, prev_lvl;
	logic [31:0]      dark_start, light_start, last_off, last_dark;
	logic [31:0]      flash_tot, steady_tot;
	logic             awaiting, meas, active, flash_on;
	logic [1:0]       meas_count;
	mode_t            mode;
	logic [SEC_W-1:0] secs;

	function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {33'd0, a} + {1'b0, b};
		return (s > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic in_band(input logic [31:0] d);
		return d >= flash_min && d <= flash_max;
	endfunction

	function automatic lamp_status_t next_status(input logic r, input logic [31:0] ts);
		logic [31:0]  span;
		logic [31:0]  total;
		logic         fin;
		lamp_status_t s;
		fin = 1'b0;
		window = {window[1:0], r};
		filt = $countones(window) >= 2;
		if (filt && !prev_lvl) begin
			span = ts - dark_start;
			last_dark = span;
			light_start = ts;
			mode = MODE_ON;
			if (awaiting && span >= min_dark) begin
				meas = 1'b1;
				awaiting = 1'b0;
				flash_tot = '0;
				steady_tot = '0;
				if (meas_count < COUNT_MAX)
					meas_count++;
				active = meas_count >= COUNT_MAX;
			end
			prev_lvl = 1'b1;
		end else if (!filt && prev_lvl) begin
			span = ts - light_start;
			last_off = ts;
			dark_start = ts;
			mode = MODE_OFF;
			if (in_band(span) && in_band(last_dark)) begin
				if (!flash_on) begin
					flash_on = 1'b1;
					mode = MODE_FLASH;
				end
				flash_tot = sat_sum(flash_tot, {32'd0, span} + {32'd0, last_dark});
			end else begin
				flash_on = 1'b0;
				if (meas && span > flash_max)
					steady_tot = sat_sum(steady_tot, {32'd0, span});
			end
			prev_lvl = 1'b0;
		end
		// quiet gap measured from the last falling edge, wraps mod 2^32
		if (meas && !filt && (ts - last_off) > end_quiet) begin
			total = sat_sum(steady_tot, {32'd0, flash_tot});
			secs = SEC_W'(total / 1000);
			active = 1'b0;
			meas = 1'b0;
			awaiting = 1'b1;
			fin = 1'b1;
		end
		s.lamp = filt;
		s.mode = mode;
		s.flash = flash_on;
		s.meas = meas;
		s.active = active;
		s.done = fin;
		s.secs = secs;
		return s;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_due.delete();
			min_dark <= MIN_DARK_RST;
			flash_min <= FLASH_MIN_RST;
			flash_max <= FLASH_MAX_RST;
			end_quiet <= END_QUIET_RST;
			window = '0;
			filt = 1'b0;
			prev_lvl = 1'b0;
			dark_start = '0;
			light_start = '0;
			last_off = '0;
			last_dark = '0;
			flash_tot = '0;
			steady_tot = '0;
			awaiting = 1'b1;
			meas = 1'b0;
			active = 1'b0;
			flash_on = 1'b0;
			meas_count = '0;
			mode = MODE_OFF;
			secs = '0;
			status_pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (status_due.size() == 0) begin
					err_count++;
					$display("%0t: status beat with nothing expected, expected none, got %h",
						$time, {lamp_level, lamp_mode, flashing, measuring,
						countdown_active, measure_done, countdown_seconds});
				end else begin
					want = status_due.pop_front();
					check_field("lamp_level", want.lamp, lamp_level);
					check_field("lamp_mode", want.mode, lamp_mode);
					check_field("flashing", want.flash, flashing);
					check_field("measuring", want.meas, measuring);
					check_field("countdown_active", want.active, countdown_active);
					check_field("measure_done", want.done, measure_done);
					check_field("countdown_seconds", want.secs, countdown_seconds);
				end
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MIN_DARK:  min_dark <= cfg_data;
					CFG_FLASH_MIN: flash_min <= cfg_data;
					CFG_FLASH_MAX: flash_max <= cfg_data;
					CFG_END_QUIET: end_quiet <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				status_due.push_back(next_status(lamp_raw, now_ms));
			status_pending <= status_due.size();
		end
		mismatches <= err_count;
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top import slpm_pkg::*; ();

	localparam int unsigned LIMIT = 400000;
	localparam int PHASE_BEATS = 215;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             lamp_raw = 1'b0;
	logic [31:0]      now_ms = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             lamp_level;
	logic [1:0]       lamp_mode;
	logic             flashing;
	logic             measuring;
	logic             countdown_active;
	logic             measure_done;
	logic [SEC_W-1:0] countdown_seconds;

	int          mismatches;
	int          status_pending;
	int unsigned cycle_count = 0;
	int          ready_style = 0;

	// stimulus-side copy of the thresholds, used to shape periods
	int          md, fmin, fmax, eq;
	logic [31:0] t_now = '0;
	int          burst_left = 0;
	int          beats_sent = 0;

	signal_lamp_period_meter_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.lamp_raw(lamp_raw), .now_ms(now_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.lamp_level(lamp_level), .lamp_mode(lamp_mode), .flashing(flashing),
		.measuring(measuring), .countdown_active(countdown_active),
		.measure_done(measure_done), .countdown_seconds(countdown_seconds)
	);

	lamp_meter_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.lamp_raw(lamp_raw), .now_ms(now_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.lamp_level(lamp_level), .lamp_mode(lamp_mode), .flashing(flashing),
		.measuring(measuring), .countdown_active(countdown_active),
		.measure_done(measure_done), .countdown_seconds(countdown_seconds),
		.mismatches(mismatches), .status_pending(status_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stall styles: always ready, coin flip, one in three, long stalls
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 256 == 0)
			ready_style <= $urandom_range(0, 3);
		case (ready_style)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (cycle_count % 3 == 0);
			default: out_ready <= (cycle_count % 32 >= 24);
		endcase
		if (cycle_count == LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_beat(input logic r, input logic [31:0] ts);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		lamp_raw <= r;
		now_ms <= ts;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		beats_sent++;
	endtask

	// one lamp period: the edge lands on the second sample at t_now, then up to
	// two extra samples inside the period; probe puts them on the quiet limit
	task automatic emit_period(input logic lvl, input logic [31:0] dur, input int nx,
		input bit probe);
		logic [31:0] a, b, tmp;
		send_beat(lvl, t_now);
		send_beat(lvl, t_now);
		if (nx > 0) begin
			if (probe && dur > eq) begin
				a = eq;
				b = eq + 1;
			end else begin
				a = $urandom_range(0, dur);
				b = $urandom_range(0, dur);
			end
			if (a > b) begin
				tmp = a;
				a = b;
				b = tmp;
			end
			send_beat(lvl, t_now + a);
			if (nx > 1)
				send_beat(lvl, t_now + b);
		end
		t_now = t_now + dur;
	endtask

	function automatic logic [31:0] period_span();
		case ($urandom_range(0, 15))
			0: return fmin;
			1: return fmax;
			2: return (fmin > 0) ? fmin - 1 : 0;
			3: return fmax + 1;
			4: return $urandom_range(0, fmin);
			5, 6: begin
				if ($urandom_range(0, 3) == 0)
					return $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
				return fmax + 1 + $urandom_range(0, 3000);
			end
			default: return $urandom_range(fmin, fmax);
		endcase
	endfunction

	function automatic logic [31:0] quiet_span();
		case ($urandom_range(0, 5))
			0: return md;
			1: return (md > 0) ? md - 1 : 0;
			2: return md + $urandom_range(0, 500);
			3: return (eq > 0) ? eq : 0;
			default: return eq + 1 + $urandom_range(0, 600);
		endcase
	endfunction

	task automatic run_random(input int goal);
		int stop_at;
		int n;
		int k;
		stop_at = beats_sent + goal;
		while (beats_sent < stop_at) begin
			k = $urandom_range(0, 9);
			if ($urandom_range(0, 7) == 0)
				t_now = $urandom;
			if (k == 0) begin
				// noise: random samples, lone glitches, time jumps
				repeat ($urandom_range(3, 12)) begin
					if ($urandom_range(0, 7) == 0)
						t_now = $urandom;
					else
						t_now = t_now + $urandom_range(0, 300);
					send_beat(1'($urandom_range(0, 1)), t_now);
				end
			end else begin
				if (k == 1)
					t_now = 32'hFFFF_FFFF - $urandom_range(0, 4000);
				n = $urandom_range(1, 8);
				repeat (n - 1) begin
					emit_period(1'b1, period_span(), $urandom_range(0, 2), 1'b0);
					emit_period(1'b0, period_span(), $urandom_range(0, 2), 1'b0);
				end
				emit_period(1'b1, period_span(), $urandom_range(0, 2), 1'b0);
				emit_period(1'b0, quiet_span(), 2, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (status_pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic apply_cfg(input int a, input int b, input int c, input int d);
		md = a;
		fmin = b;
		fmax = c;
		eq = d;
		cfg_we <= 1'b1;
		cfg_index <= CFG_MIN_DARK;
		cfg_data <= CFG_W'(a);
		@(posedge clk);
		cfg_index <= CFG_FLASH_MIN;
		cfg_data <= CFG_W'(b);
		@(posedge clk);
		cfg_index <= CFG_FLASH_MAX;
		cfg_data <= CFG_W'(c);
		@(posedge clk);
		cfg_index <= CFG_END_QUIET;
		cfg_data <= CFG_W'(d);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int lo;
		md = MIN_DARK_RST;
		fmin = FLASH_MIN_RST;
		fmax = FLASH_MAX_RST;
		eq = END_QUIET_RST;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// reset thresholds; first rise measured from time zero
		emit_period(1'b0, 32'd2000, 0, 1'b0);
		emit_period(1'b1, 32'd400, 0, 1'b0);
		emit_period(1'b0, 32'd400, 0, 1'b0);
		emit_period(1'b1, 32'd800, 0, 1'b0);
		emit_period(1'b0, 32'd800, 0, 1'b0);
		emit_period(1'b1, 32'd400, 0, 1'b0);
		emit_period(1'b0, 32'd801, 0, 1'b0);
		emit_period(1'b1, 32'd801, 0, 1'b0);
		emit_period(1'b0, 32'd2001, 2, 1'b1);
		send_beat(1'b1, t_now);
		send_beat(1'b0, 32'hFFFF_FFFF);
		run_random(PHASE_BEATS);

		for (int p = 1; p <= 6; p++) begin
			wait_drain();
			case (p)
				1: apply_cfg(0, 0, 0, 0);
				2: apply_cfg(65535, 65535, 65535, 65535);
				3: apply_cfg(500, 800, 400, 1000);   // inverted flash band
				4: begin
					lo = $urandom_range(0, 100);
					apply_cfg($urandom_range(0, 300), lo, lo + $urandom_range(0, 200),
						$urandom_range(0, 500));
				end
				5: apply_cfg(2000, 500, 500, 2000);
				default: apply_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
			endcase
			run_random(PHASE_BEATS);
		end

		wait_drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
